>>> sv/mp80_pkg.sv
// Shared types, constants and functions for the masked PRESENT-80 encryption pipeline.
// This package has no dependencies. Every other file in the project uses it.
package mp80_pkg;

    // Default round count. The top level hands it down as a parameter.
    localparam int NUM_ROUNDS_DEF = 31;
    localparam int BLOCK_W        = 64;
    localparam int KEY_HI_W       = 16;
    localparam int KEY_LO_W       = 64;
    localparam int KEY_W          = KEY_HI_W + KEY_LO_W;
    localparam int RND_W          = 5;
    localparam int KEY_ROT        = 61;
    localparam int RC_LSB         = 15;

    // One pipeline slot: the masked state, the running key and both masks.
    typedef struct packed {
        logic                valid;
        logic [BLOCK_W-1:0]  state;
        logic [KEY_HI_W-1:0] key_hi;
        logic [KEY_LO_W-1:0] key_lo;
        logic [BLOCK_W-1:0]  mask_in;
        logic [BLOCK_W-1:0]  mask_out;
    } t_stage;

    // PRESENT 4-bit S-box.
    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    // Forward bit permutation: bit i moves to 16*i mod 63, bit 63 stays put.
    function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[(i == BLOCK_W-1) ? BLOCK_W-1 : (16 * i) % (BLOCK_W-1)] = x[i];
        end
        return r;
    endfunction

    // Inverse bit permutation: bit i moves to 4*i mod 63, bit 63 stays put.
    function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[(i == BLOCK_W-1) ? BLOCK_W-1 : (4 * i) % (BLOCK_W-1)] = x[i];
        end
        return r;
    endfunction

    // Sixteen masked S-boxes: S(x ^ a) ^ b on every nibble.
    function automatic logic [BLOCK_W-1:0] masked_subst(input logic [BLOCK_W-1:0] x,
                                                        input logic [BLOCK_W-1:0] a,
                                                        input logic [BLOCK_W-1:0] b);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int k = 0; k < BLOCK_W/4; k++) begin
            r[4*k +: 4] = sbox(x[4*k +: 4] ^ a[4*k +: 4]) ^ b[4*k +: 4];
        end
        return r;
    endfunction

    // Key schedule step: rotate left by 61, S-box on the top nibble,
    // round counter into bits 19..15.
    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                    input logic [RND_W-1:0] rnd);
        logic [KEY_W-1:0] n;
        n = {k[KEY_W-KEY_ROT-1:0], k[KEY_W-1:KEY_W-KEY_ROT]};
        n[KEY_W-1 -: 4] = sbox(n[KEY_W-1 -: 4]);
        n[RC_LSB +: RND_W] = n[RC_LSB +: RND_W] ^ rnd;
        return n;
    endfunction

    // Round key: the top 64 bits of the key register.
    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

endpackage

>>> sv/mp80_round.sv
// One round cell of the masked PRESENT-80 pipeline: key update, masked S-boxes,
// bit permutation and round key addition, with a register on the way out.
// It depends on mp80_pkg.
module mp80_round #(
    parameter int ROUND = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mp80_pkg::t_stage i_stage,
    output mp80_pkg::t_stage o_stage
);
    import mp80_pkg::*;

    localparam logic [RND_W-1:0] RND = RND_W'(ROUND);

    logic               r_valid;
    t_stage             r_data;
    t_stage             n_data;
    logic [KEY_W-1:0]   key_next;
    logic [BLOCK_W-1:0] mask_a;
    logic [BLOCK_W-1:0] mask_b;

    // Odd rounds strip mask_in and leave the state under mask_out; even rounds the reverse.
    always_comb begin
        key_next = key_update({i_stage.key_hi, i_stage.key_lo}, RND);
        if (RND[0]) begin
            mask_a = i_stage.mask_in;
            mask_b = perm_inv(i_stage.mask_out);
        end else begin
            mask_a = i_stage.mask_out;
            mask_b = perm_inv(i_stage.mask_in);
        end
        n_data          = i_stage;
        n_data.key_hi   = key_next[KEY_W-1 -: KEY_HI_W];
        n_data.key_lo   = key_next[KEY_LO_W-1:0];
        n_data.state    = perm_fwd(masked_subst(i_stage.state, mask_a, mask_b))
                          ^ round_key(key_next);
    end

    // The valid bit is reset; the payload simply follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
        r_data <= n_data;
    end

    always_comb begin
        o_stage       = r_data;
        o_stage.valid = r_valid;
    end

endmodule

>>> sv/masked_present80_encrypt.sv
// Top level of the masked PRESENT-80 encryption pipeline: input register with key
// whitening followed by a chain of NUM_ROUNDS round cells. It depends on mp80_pkg
// and mp80_round.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------------
//   command   start / busy         i_masked_block, i_key_low, i_key_high,
//                                  i_mask_in, i_mask_out
//   result    o_valid (strobe)     o_masked_cipher
//
// A block is taken in every cycle; busy stays low. Each block passes through the
// whitening register and then the round cells in order, each of which registers
// its output. Synchronous reset clears only the valid bits of the chain.
// The result is shown for one cycle and the receiver cannot stall it.
module masked_present80_encrypt #(
    parameter int NUM_ROUNDS = mp80_pkg::NUM_ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mp80_pkg::BLOCK_W-1:0]  i_masked_block,
    input  logic [mp80_pkg::KEY_LO_W-1:0] i_key_low,
    input  logic [mp80_pkg::KEY_HI_W-1:0] i_key_high,
    input  logic [mp80_pkg::BLOCK_W-1:0]  i_mask_in,
    input  logic [mp80_pkg::BLOCK_W-1:0]  i_mask_out,
    output logic                          o_valid,
    output logic [mp80_pkg::BLOCK_W-1:0]  o_masked_cipher
);
    import mp80_pkg::*;

    logic   accept;
    logic   r_valid;
    t_stage r_in;
    t_stage n_in;
    t_stage link [0:NUM_ROUNDS];

    // The pipeline never stalls, so a command is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Whitening: the first round key goes in as the block is registered.
    always_comb begin
        n_in.valid    = accept;
        n_in.key_hi   = i_key_high;
        n_in.key_lo   = i_key_low;
        n_in.mask_in  = i_mask_in;
        n_in.mask_out = i_mask_out;
        n_in.state    = i_masked_block ^ round_key({i_key_high, i_key_low});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
        r_in <= n_in;
    end

    always_comb begin
        link[0]       = r_in;
        link[0].valid = r_valid;
    end

    // Chain of round cells, one per round.
    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        mp80_round #(
            .ROUND (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (link[g-1]),
            .o_stage (link[g])
        );
    end

    assign o_valid         = link[NUM_ROUNDS].valid;
    assign o_masked_cipher = link[NUM_ROUNDS].state;

endmodule

>>> sv/mp80_checker.sv
// Port-level checker for masked_present80_encrypt, with the bind that attaches it.
// It depends on mp80_pkg and on the top level's port list.
module mp80_checker #(
    parameter int NUM_ROUNDS = mp80_pkg::NUM_ROUNDS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    import mp80_pkg::*;

    localparam int LAT = NUM_ROUNDS + 1;

    // Expected strobe: every transfer moves down a line cleared by reset.
    logic [LAT-1:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else begin
            r_exp <= {r_exp[LAT-2:0], start && !busy};
        end
    end

    // Each transfer yields exactly one result after the fixed latency, and none other.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == r_exp[LAT-1])
        else $error("result strobe does not match a transfer %0d cycles earlier", LAT);

    // Nothing comes out in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // The pipeline takes a block in every cycle.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind masked_present80_encrypt mp80_checker #(
    .NUM_ROUNDS (NUM_ROUNDS)
) u_mp80_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

>>> bench/tb_masked_present80_encrypt.sv
// Self-checking testbench for masked_present80_encrypt: known PRESENT-80 vectors,
// masked variants of them, and random blocks checked against a local cipher model.
// It depends on mp80_pkg and the masked_present80_encrypt top level only.
`timescale 1ns / 1ps

module tb_masked_present80_encrypt;

    localparam int ROUNDS      = mp80_pkg::NUM_ROUNDS_DEF;
    localparam int LATENCY     = ROUNDS + 1;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_JOBS = 1650;
    localparam int MAX_REPORTS = 10;

    // S-box packed as nibbles: entry n sits at bits 4n+3..4n.
    localparam logic [63:0] SBOX_NIBS = 64'h21748FE3DA09B65C;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One block to encrypt, plus an optional hand-computed result.
    typedef struct packed {
        logic [63:0] blk;
        logic [63:0] klo;
        logic [15:0] khi;
        logic [63:0] m_in;
        logic [63:0] m_out;
        logic        known;
        logic [63:0] ct;
    } cipher_job_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        o_valid;
    logic [63:0] o_masked_cipher;

    cipher_job_t cur_job;
    cipher_job_t directed_jobs[$];
    logic [63:0] pending_ciphers[$];
    logic [63:0] want;
    int          err_count;
    int          cycle_count;

    masked_present80_encrypt #(
        .NUM_ROUNDS(ROUNDS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_masked_block (cur_job.blk),
        .i_key_low      (cur_job.klo),
        .i_key_high     (cur_job.khi),
        .i_mask_in      (cur_job.m_in),
        .i_mask_out     (cur_job.m_out),
        .o_valid        (o_valid),
        .o_masked_cipher(o_masked_cipher)
    );

    // Free-running clock, 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // PRESENT bit layer: bit i goes to 16*i mod 63, bit 63 is fixed.
    function automatic logic [63:0] spread_bits(input logic [63:0] x);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 63; i++) begin
            r[(16 * i) % 63] = x[i];
        end
        r[63] = x[63];
        return r;
    endfunction

    // Inverse bit layer: bit i goes to 4*i mod 63, bit 63 is fixed.
    function automatic logic [63:0] gather_bits(input logic [63:0] x);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 63; i++) begin
            r[(4 * i) % 63] = x[i];
        end
        r[63] = x[63];
        return r;
    endfunction

    // Masked substitution layer: every nibble becomes S(x ^ a) ^ b.
    function automatic logic [63:0] masked_sbox_layer(input logic [63:0] x,
                                                      input logic [63:0] a,
                                                      input logic [63:0] b);
        logic [63:0] r;
        logic [3:0]  n;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            n = x[4*k +: 4] ^ a[4*k +: 4];
            r[4*k +: 4] = SBOX_NIBS[4*n +: 4] ^ b[4*k +: 4];
        end
        return r;
    endfunction

    // Key register step: rotate left by 61, substitute the top nibble,
    // fold the round counter into bits 19..15.
    function automatic logic [79:0] advance_key(input logic [79:0] k, input logic [4:0] rc);
        logic [79:0] n;
        n = {k[18:0], k[79:19]};
        n[79:76] = SBOX_NIBS[4*n[79:76] +: 4];
        n[19:15] = n[19:15] ^ rc;
        return n;
    endfunction

    // Full masked encryption of one job; the mask alternates between
    // mask_in and mask_out from round to round.
    function automatic logic [63:0] masked_encrypt(input cipher_job_t j);
        logic [79:0] kreg;
        logic [63:0] st;
        logic [63:0] inv_in;
        logic [63:0] inv_out;
        logic [4:0]  rc;
        kreg    = {j.khi, j.klo};
        inv_in  = gather_bits(j.m_in);
        inv_out = gather_bits(j.m_out);
        st      = j.blk ^ kreg[79:16];
        rc      = 5'd0;
        for (int r = 1; r <= ROUNDS; r++) begin
            rc   = rc + 5'd1;
            kreg = advance_key(kreg, rc);
            if (rc[0]) begin
                st = masked_sbox_layer(st, j.m_in, inv_out);
            end else begin
                st = masked_sbox_layer(st, j.m_out, inv_in);
            end
            st = spread_bits(st) ^ kreg[79:16];
        end
        return st;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic note_error(input string what, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_v, got_v);
        end
    endtask

    task automatic add_row(input logic [63:0] blk, input logic [63:0] klo,
                           input logic [15:0] khi, input logic [63:0] m_in,
                           input logic [63:0] m_out, input logic known,
                           input logic [63:0] ct);
        cipher_job_t j;
        j.blk   = blk;
        j.klo   = klo;
        j.khi   = khi;
        j.m_in  = m_in;
        j.m_out = m_out;
        j.known = known;
        j.ct    = ct;
        directed_jobs.push_back(j);
    endtask

    // Present one job and hold it until the transfer happens.
    task automatic send_job(input cipher_job_t j);
        @(negedge i_clk);
        start   <= 1'b1;
        cur_job <= j;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start; n sets how long it stays low.
    task automatic idle_for(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Random gaps between commands, after about 12 commands in a hundred unless steady is set.
    task automatic maybe_gap(input bit steady);
        if (!steady && $urandom_range(0, 99) < 12) begin
            idle_for($urandom_range(1, 3));
        end
    endtask

    // Random job: mostly fully random, with a share of structured masks and keys.
    function automatic cipher_job_t random_job();
        cipher_job_t j;
        int          pick;
        j.blk   = rand64();
        j.klo   = rand64();
        j.khi   = 16'($urandom_range(0, 65535));
        j.m_in  = rand64();
        j.m_out = rand64();
        j.known = 1'b0;
        j.ct    = '0;
        pick    = $urandom_range(0, 99);
        if (pick >= 60 && pick < 75) begin
            j.m_in  = '0;
            j.m_out = '0;
        end else if (pick >= 75 && pick < 85) begin
            j.m_out = j.m_in;
        end else if (pick >= 85 && pick < 95) begin
            j.klo = $urandom_range(0, 1) ? ONES : '0;
            j.khi = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (pick >= 95) begin
            j.blk  = 64'd1 << $urandom_range(0, 63);
            j.m_in = 64'd1 << $urandom_range(0, 63);
        end
        return j;
    endfunction

    // Result checking and expectation capture, both on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid !== 1'b0) begin
                if (pending_ciphers.size() == 0) begin
                    note_error("result with no block outstanding", 'x, o_masked_cipher);
                end else begin
                    want = pending_ciphers.pop_front();
                    if (o_valid !== 1'b1 || o_masked_cipher !== want) begin
                        note_error("masked_cipher mismatch", want, o_masked_cipher);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                pending_ciphers.push_back(cur_job.known ? cur_job.ct : masked_encrypt(cur_job));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cipher_job_t j;
        err_count   = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        cur_job     = '0;

        // Published PRESENT-80 vectors with zero masks, then masked forms of them.
        add_row('0,   '0,   16'h0000, '0, '0, 1'b1, 64'h5579C1387B228445);
        add_row('0,   ONES, 16'hFFFF, '0, '0, 1'b1, 64'hE72C46C0F5945049);
        add_row(ONES, '0,   16'h0000, '0, '0, 1'b1, 64'hA112FFC72F68417B);
        add_row(ONES, ONES, 16'hFFFF, '0, '0, 1'b1, 64'h3333DCD3213210D2);
        add_row(ONES, '0, 16'h0000, ONES, ONES, 1'b1, 64'hAA863EC784DD7BBA);
        add_row(ONES, '0, 16'h0000, ONES, '0,   1'b1, 64'h5579C1387B228445);
        add_row('0,   '0, 16'h0000, '0,   ONES, 1'b1, 64'hAA863EC784DD7BBA);
        add_row(64'h5A5A5A5A5A5A5A5A, ONES, 16'hFFFF, 64'hA5A5A5A5A5A5A5A5,
                64'h5A5A5A5A5A5A5A5A, 1'b1, 64'h696986897B684A88);
        // Split key halves, single bits and patterned masks.
        add_row('0, '0,   16'hFFFF, '0, '0, 1'b0, '0);
        add_row('0, ONES, 16'h0000, '0, '0, 1'b0, '0);
        add_row(64'h8000000000000000, 64'h1, 16'h8000, 64'h1, 64'h8000000000000000, 1'b0, '0);
        add_row(64'h1, 64'h8000000000000000, 16'h0001, 64'h8000000000000000, 64'h1, 1'b0, '0);
        add_row(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 16'h1234,
                64'hF0F0F0F0F0F0F0F0, 64'h0F0F0F0F0F0F0F0F, 1'b0, '0);
        add_row(64'hCCCCCCCCCCCCCCCC, 64'h3333333333333333, 16'hAAAA,
                ONES, ONES, 1'b0, '0);
        add_row(ONES, ONES, 16'hFFFF, ONES, '0, 1'b0, '0);
        add_row(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 16'h5555,
                64'h3C3C3C3C3C3C3C3C, 64'h3C3C3C3C3C3C3C3C, 1'b0, '0);

        // Hold synchronous reset, then release it.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (directed_jobs[n]) begin
            send_job(directed_jobs[n]);
            maybe_gap(1'b0);
        end

        // Random part, with a stretch of back-to-back transfers in the middle.
        for (int n = 0; n < RANDOM_JOBS; n++) begin
            j = random_job();
            send_job(j);
            maybe_gap(n >= 700 && n < 1000);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain the pipeline, then watch for stray results.
        while (pending_ciphers.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
